// ===== rtl/spq_pkg.sv =====
// Package for the sorted priority queue: request, response and slot types, codes, key function.
`default_nettype none
package spq_pkg;

   localparam int NODE_WIDTH  = 4;
   localparam int WORD_WIDTH  = 32;
   localparam int COUNT_WIDTH = 6;

   localparam logic FUNC_PUSH = 1'b0;
   localparam logic FUNC_POP  = 1'b1;

   typedef struct packed {
      logic                  func;
      logic [NODE_WIDTH-1:0] node_in;
      logic [WORD_WIDTH-1:0] cost_in;
      logic [WORD_WIDTH-1:0] heur_in;
   } spq_req_type;

   typedef struct packed {
      logic                   pop_valid;
      logic [NODE_WIDTH-1:0]  node_out;
      logic [WORD_WIDTH-1:0]  cost_out;
      logic [WORD_WIDTH-1:0]  heur_out;
      logic                   push_dropped;
      logic [COUNT_WIDTH-1:0] entry_count;
   } spq_rsp_type;

   typedef struct packed {
      logic [NODE_WIDTH-1:0] node;
      logic [WORD_WIDTH-1:0] cost;
      logic [WORD_WIDTH-1:0] heur;
   } spq_entry_type;

   typedef struct packed {
      logic push;
      logic pop;
   } spq_ctl_type;

   function automatic logic [WORD_WIDTH-1:0] spq_key(
      input logic [WORD_WIDTH-1:0] cost,
      input logic [WORD_WIDTH-1:0] heur
   );
      return (heur != '0) ? heur : cost;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/spq_cell.sv =====
// One slot of the sorted chain: compares against the incoming key and shifts with its neighbors.
`default_nettype none
module spq_cell (
   input  wire                         clock,
   input  wire spq_pkg::spq_ctl_type   ctl,
   input  wire spq_pkg::spq_entry_type new_entry,
   input  wire spq_pkg::spq_entry_type left_entry,
   input  wire spq_pkg::spq_entry_type right_entry,
   input  wire                         occupied,
   input  wire                         left_le,
   output spq_pkg::spq_entry_type      entry,
   output logic                        le
);

   spq_pkg::spq_entry_type entry_ff;
   spq_pkg::spq_entry_type entry_in;

   assign le = occupied &&
      (spq_pkg::spq_key(entry_ff.cost, entry_ff.heur) <=
       spq_pkg::spq_key(new_entry.cost, new_entry.heur));

   always_comb begin
      entry_in = entry_ff;
      if (ctl.push) begin
         if (!le) begin
            entry_in = left_le ? new_entry : left_entry;
         end
      end else if (ctl.pop) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule
`default_nettype wire

// ===== rtl/sorted_priority_queue_top.sv =====
// Top level of the sorted priority queue: chain of slot cells, entry count and response register.
//
//   Channel  Direction  Handshake          Payload
//   req      in         req_valid/stall    spq_req_type (func, node, cost, heuristic)
//   rsp      out        rsp_valid/stall    spq_rsp_type (popped entry, dropped flag, count)
//
// For each request, all cells compare their keys with the pushed key and shift
// in the same cycle, and the result lands in the response register at that edge.
// A new request is taken each cycle while the response register is empty or being read.
// Reset clears the entry count and the response valid; slot contents need no clearing.
// While rsp_stall holds a waiting response, req_stall is high and no request is taken.
`default_nettype none
module sorted_priority_queue_top #(
   parameter int QUEUE_DEPTH = 32
) (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       req_valid,
   output logic                      req_stall,
   input  wire spq_pkg::spq_req_type req_data,
   output logic                      rsp_valid,
   input  wire                       rsp_stall,
   output spq_pkg::spq_rsp_type      rsp_data
);

   localparam int CountWidth    = $clog2(QUEUE_DEPTH + 1);
   localparam int CountOutWidth = spq_pkg::COUNT_WIDTH;

   logic [CountWidth-1:0] count_ff;
   logic [CountWidth-1:0] count_in;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   spq_pkg::spq_rsp_type  rsp_data_ff;
   spq_pkg::spq_rsp_type  rsp_data_in;

   logic                   accept;
   logic                   full;
   logic                   empty;
   spq_pkg::spq_ctl_type   ctl;
   spq_pkg::spq_entry_type new_entry;
   spq_pkg::spq_entry_type cell_entry [QUEUE_DEPTH];
   logic                   cell_le    [QUEUE_DEPTH];

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign full      = (count_ff == CountWidth'(QUEUE_DEPTH));
   assign empty     = (count_ff == '0);

   assign new_entry.node = req_data.node_in;
   assign new_entry.cost = req_data.cost_in;
   assign new_entry.heur = req_data.heur_in;

   assign ctl.push = accept && (req_data.func == spq_pkg::FUNC_PUSH) && !full;
   assign ctl.pop  = accept && (req_data.func == spq_pkg::FUNC_POP) && !empty;

   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      spq_pkg::spq_entry_type left_entry;
      spq_pkg::spq_entry_type right_entry;
      logic                   left_le;

      if (i == 0) begin : g_first
         assign left_entry = new_entry;
         assign left_le    = 1'b1;
      end else begin : g_inner
         assign left_entry = cell_entry[i-1];
         assign left_le    = cell_le[i-1];
      end

      if (i == QUEUE_DEPTH - 1) begin : g_last
         assign right_entry = new_entry;
      end else begin : g_mid
         assign right_entry = cell_entry[i+1];
      end

      spq_cell u_cell (
         .clock       (clock),
         .ctl         (ctl),
         .new_entry   (new_entry),
         .left_entry  (left_entry),
         .right_entry (right_entry),
         .occupied    (count_ff > CountWidth'(i)),
         .left_le     (left_le),
         .entry       (cell_entry[i]),
         .le          (cell_le[i])
      );
   end

   always_comb begin
      count_in = count_ff;
      if (ctl.push) begin
         count_in = count_ff + CountWidth'(1);
      end else if (ctl.pop) begin
         count_in = count_ff - CountWidth'(1);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_comb begin
      rsp_data_in              = rsp_data_ff;
      if (accept) begin
         rsp_data_in              = '0;
         rsp_data_in.entry_count  = CountOutWidth'(count_in);
         if (req_data.func == spq_pkg::FUNC_POP) begin
            if (!empty) begin
               rsp_data_in.pop_valid = 1'b1;
               rsp_data_in.node_out  = cell_entry[0].node;
               rsp_data_in.cost_out  = cell_entry[0].cost;
               rsp_data_in.heur_out  = cell_entry[0].heur;
            end
         end else begin
            rsp_data_in.push_dropped = full;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CountWidth'(QUEUE_DEPTH))
      else $error("entry count exceeds queue depth");

   a_push_grows : assert property (@(posedge clock) disable iff (reset)
      ctl.push |=> count_ff == $past(count_ff) + CountWidth'(1))
      else $error("accepted push did not grow the count");

   a_pop_result : assert property (@(posedge clock) disable iff (reset)
      ctl.pop |=> rsp_valid_ff && rsp_data_ff.pop_valid && !rsp_data_ff.push_dropped)
      else $error("pop of a held entry did not return it");

   a_front_sorted : assert property (@(posedge clock) disable iff (reset)
      count_ff >= CountWidth'(2) |->
         spq_pkg::spq_key(cell_entry[0].cost, cell_entry[0].heur) <=
         spq_pkg::spq_key(cell_entry[1].cost, cell_entry[1].heur))
      else $error("front slots are out of order");

endmodule
`default_nettype wire
